>>> design/event_channel_demux_top_macros.svh
// ---------------------------------------------------------------------------
// event_channel_demux_top_macros
// Assertion macros for the event channel demux top design file.
// ---------------------------------------------------------------------------
`ifndef EVENT_CHANNEL_DEMUX_TOP_MACROS_SVH
`define EVENT_CHANNEL_DEMUX_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define ECD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ECD_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define ECD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ECD_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

>>> design/ecd_pkg.sv
// ---------------------------------------------------------------------------
// ecd_pkg
// Shared types and constants for the event channel demux.
// ---------------------------------------------------------------------------
package ecd_pkg;

    localparam int DEF_WORD_BITS    = 64;
    localparam int DEF_NUM_CHANNELS = 4096;
    localparam int CHAN_W           = 12;
    localparam int KIND_W           = 3;

    // field slots inside one stored row
    localparam int F_PEND  = 0;
    localparam int F_MASK  = 1;
    localparam int F_IPI   = 2;
    localparam int F_OWN   = 3;
    localparam int F_DIR   = 4;
    localparam int F_QUE   = 5;
    localparam int N_FIELD = 6;

    typedef enum logic [KIND_W-1:0] {
        K_RAISE    = 3'd0,
        K_MASK     = 3'd1,
        K_UNMASK   = 3'd2,
        K_HANDLERS = 3'd3,
        K_IPI      = 3'd4,
        K_UPMASK   = 3'd5,
        K_ACK      = 3'd6,
        K_NONE     = 3'd7
    } kind_t;

endpackage

>>> design/ecd_ram.sv
// ---------------------------------------------------------------------------
// ecd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ecd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/event_channel_demux_top.sv
// ---------------------------------------------------------------------------
// event_channel_demux_top
// Two-level event channel pending bitmap with acknowledge scan.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one command word: raise, mask,
// unmask, set handlers, mark IPI, set upcall mask or acknowledge. Every
// word gives exactly one result word on the output channel
// (out_valid/out_stall).
// Per-channel bits live in one RAM, one row per word of WORD_BITS channels;
// selector and upcall flags sit in flops. One command at a time:
// - upcall mask / unknown / out-of-range: finish state, then output register
// - bitmap update: read, modify-write, result
// - acknowledge: read the lowest selected word, drop it if found empty and
//   scan the selector again; straight to the result when no word is selected.
// in_stall is high while a command is in flight or a result cannot be
// loaded. A stalled result holds until taken; the next command waits.
// Reset: per-row valid flops make every row read as its reset value
// (all masked, nothing pending), selector clear, upcall masked. No
// clearing pass; commands are taken straight after reset.
// ---------------------------------------------------------------------------
`include "event_channel_demux_top_macros.svh"

module event_channel_demux_top
    import ecd_pkg::*;
#(
    parameter int WORD_BITS    = DEF_WORD_BITS,
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [CHAN_W-1:0] channel,
    input  logic              has_direct_handler,
    input  logic              has_queued_handler,
    input  logic              owned_by_this_cpu,
    input  logic              upcall_mask_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              delivered,
    output logic [CHAN_W-1:0] delivered_channel,
    output logic              call_direct,
    output logic              queue_handler,
    output logic              callback_request,
    output logic              previous_upcall_mask,
    output logic              upcall_pending_now
);

    localparam int NUM_WORDS = (NUM_CHANNELS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int POS_W     = $clog2(WORD_BITS);
    localparam int ROW_W     = N_FIELD * WORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RMW,
        S_SCAN,
        S_ACK,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    kind_t              kind_reg, kind_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               hd_reg, hd_next;
    logic               hq_reg, hq_next;
    logic               own_reg, own_next;
    logic               prev_mask_reg, prev_mask_next;

    logic               res_del_reg, res_del_next;
    logic [CHAN_W-1:0]  res_chan_reg, res_chan_next;
    logic               res_dir_reg, res_dir_next;
    logic               res_que_reg, res_que_next;

    logic [NUM_WORDS-1:0] sel_reg, sel_next;
    logic [NUM_WORDS-1:0] row_vld_reg, row_vld_next;
    logic                 rvld_reg;
    logic                 upc_pend_reg, upc_pend_next;
    logic                 upc_mask_reg, upc_mask_next;

    logic               out_valid_reg, out_valid_next;
    logic               o_del_reg, o_del_next;
    logic [CHAN_W-1:0]  o_chan_reg, o_chan_next;
    logic               o_dir_reg, o_dir_next;
    logic               o_que_reg, o_que_next;
    logic               o_cb_reg, o_cb_next;
    logic               o_prev_reg, o_prev_next;
    logic               o_upc_reg, o_upc_next;

    logic                 ram_we;
    logic [WORD_W-1:0]    ram_raddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic [ROW_W-1:0]     ram_rdata;

    logic [ROW_W-1:0]     row;
    logic [WORD_BITS-1:0] pend, mask, ipi, own, dir, que;
    logic [WORD_BITS-1:0] n_pend, n_mask, n_ipi, n_own, n_dir, n_que;
    logic [WORD_BITS-1:0] bit_sel, dlv, dlv_left, served_bit;
    logic [POS_W-1:0]     first_pos;
    logic [WORD_W-1:0]    first_word;
    logic [WORD_W-1:0]    in_word;
    logic [POS_W-1:0]     in_pos;
    logic                 in_range;
    logic                 accept;
    logic                 do_select;
    logic [31:0]          served_full;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign in_range = ({1'b0, channel} < (CHAN_W + 1)'(NUM_CHANNELS));
    assign in_word  = WORD_W'(32'(channel) / WORD_BITS);
    assign in_pos   = POS_W'(32'(channel) % WORD_BITS);

    ecd_ram
    #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_WORDS),
        .AW    (WORD_W)
    )
    u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // lowest selected word
    always_comb
    begin
        first_word = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
        begin
            if (sel_reg[i])
            begin
                first_word = WORD_W'(i);
            end
        end
    end

    // a row never written reads as its reset value
    always_comb
    begin
        if (rvld_reg)
        begin
            row = ram_rdata;
        end
        else
        begin
            row = '0;
            row[F_MASK*WORD_BITS +: WORD_BITS] = '1;
        end
    end

    assign pend = row[F_PEND*WORD_BITS +: WORD_BITS];
    assign mask = row[F_MASK*WORD_BITS +: WORD_BITS];
    assign ipi  = row[F_IPI*WORD_BITS  +: WORD_BITS];
    assign own  = row[F_OWN*WORD_BITS  +: WORD_BITS];
    assign dir  = row[F_DIR*WORD_BITS  +: WORD_BITS];
    assign que  = row[F_QUE*WORD_BITS  +: WORD_BITS];

    assign bit_sel = WORD_BITS'(1) << pos_reg;
    assign dlv     = pend & ~mask & ~(ipi & ~own);

    always_comb
    begin
        first_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (dlv[i])
            begin
                first_pos = POS_W'(i);
            end
        end
    end

    assign served_bit  = WORD_BITS'(1) << first_pos;
    assign dlv_left    = dlv & ~served_bit;
    assign served_full = 32'(word_reg) * WORD_BITS + 32'(first_pos);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        word_next      = word_reg;
        pos_next       = pos_reg;
        hd_next        = hd_reg;
        hq_next        = hq_reg;
        own_next       = own_reg;
        prev_mask_next = prev_mask_reg;
        res_del_next   = res_del_reg;
        res_chan_next  = res_chan_reg;
        res_dir_next   = res_dir_reg;
        res_que_next   = res_que_reg;
        sel_next       = sel_reg;
        row_vld_next   = row_vld_reg;
        upc_pend_next  = upc_pend_reg;
        upc_mask_next  = upc_mask_reg;
        out_valid_next = out_valid_reg;
        o_del_next     = o_del_reg;
        o_chan_next    = o_chan_reg;
        o_dir_next     = o_dir_reg;
        o_que_next     = o_que_reg;
        o_cb_next      = o_cb_reg;
        o_prev_next    = o_prev_reg;
        o_upc_next     = o_upc_reg;

        ram_we    = 1'b0;
        ram_raddr = word_reg;
        n_pend    = pend;
        n_mask    = mask;
        n_ipi     = ipi;
        n_own     = own;
        n_dir     = dir;
        n_que     = que;
        do_select = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = in_word;
                if (accept)
                begin
                    kind_next      = kind_t'(kind);
                    word_next      = in_word;
                    pos_next       = in_pos;
                    hd_next        = has_direct_handler;
                    hq_next        = has_queued_handler;
                    own_next       = owned_by_this_cpu;
                    prev_mask_next = upc_mask_reg;
                    res_del_next   = 1'b0;
                    res_chan_next  = '0;
                    res_dir_next   = 1'b0;
                    res_que_next   = 1'b0;
                    if (kind_t'(kind) == K_ACK)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (kind_t'(kind) == K_UPMASK)
                    begin
                        upc_mask_next = upcall_mask_value;
                        state_next    = S_FIN;
                    end
                    else if (kind <= KIND_W'(K_IPI) && in_range)
                    begin
                        state_next = S_RMW;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_RMW:
            begin
                case (kind_reg)
                    K_RAISE:
                    begin
                        if ((pend & bit_sel) == '0)
                        begin
                            n_pend    = pend | bit_sel;
                            do_select = ((mask & bit_sel) == '0);
                        end
                    end
                    K_MASK:
                    begin
                        n_mask = mask | bit_sel;
                    end
                    K_UNMASK:
                    begin
                        n_mask    = mask & ~bit_sel;
                        do_select = ((pend & bit_sel) != '0);
                    end
                    K_HANDLERS:
                    begin
                        n_dir = hd_reg ? (dir | bit_sel) : (dir & ~bit_sel);
                        n_que = hq_reg ? (que | bit_sel) : (que & ~bit_sel);
                        if (hd_reg || hq_reg)
                        begin
                            n_mask    = mask & ~bit_sel;
                            do_select = ((pend & bit_sel) != '0);
                        end
                        else
                        begin
                            n_mask = mask | bit_sel;
                        end
                    end
                    K_IPI:
                    begin
                        n_ipi = ipi | bit_sel;
                        n_own = own_reg ? (own | bit_sel) : (own & ~bit_sel);
                    end
                    default:
                    begin
                    end
                endcase
                if (do_select && !sel_reg[word_reg])
                begin
                    sel_next[word_reg] = 1'b1;
                    upc_pend_next      = 1'b1;
                end
                ram_we                = 1'b1;
                row_vld_next[word_reg] = 1'b1;
                state_next            = S_FIN;
            end

            S_SCAN:
            begin
                ram_raddr = first_word;
                if (sel_reg == '0)
                begin
                    upc_pend_next = 1'b0;
                    state_next    = S_FIN;
                end
                else
                begin
                    word_next  = first_word;
                    state_next = S_ACK;
                end
            end

            S_ACK:
            begin
                if (dlv == '0)
                begin
                    // empty word: drop it and look again
                    sel_next[word_reg] = 1'b0;
                    state_next         = S_SCAN;
                end
                else
                begin
                    n_pend                 = pend & ~served_bit;
                    ram_we                 = 1'b1;
                    row_vld_next[word_reg] = 1'b1;
                    res_del_next           = 1'b1;
                    res_chan_next          = served_full[CHAN_W-1:0];
                    res_dir_next           = dir[first_pos];
                    res_que_next           = que[first_pos];
                    if (dlv_left == '0)
                    begin
                        sel_next[word_reg] = 1'b0;
                    end
                    if (sel_next == '0)
                    begin
                        upc_pend_next = 1'b0;
                    end
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_del_next     = res_del_reg;
                    o_chan_next    = res_chan_reg;
                    o_dir_next     = res_dir_reg;
                    o_que_next     = res_que_reg;
                    o_cb_next      = upc_pend_reg && !upc_mask_reg;
                    o_prev_next    = prev_mask_reg;
                    o_upc_next     = upc_pend_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ram_wdata = {n_que, n_dir, n_own, n_ipi, n_mask, n_pend};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= '0;
            row_vld_reg   <= '0;
            rvld_reg      <= 1'b0;
            upc_pend_reg  <= 1'b0;
            upc_mask_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            row_vld_reg   <= row_vld_next;
            rvld_reg      <= row_vld_reg[ram_raddr];
            upc_pend_reg  <= upc_pend_next;
            upc_mask_reg  <= upc_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        word_reg      <= word_next;
        pos_reg       <= pos_next;
        hd_reg        <= hd_next;
        hq_reg        <= hq_next;
        own_reg       <= own_next;
        prev_mask_reg <= prev_mask_next;
        res_del_reg   <= res_del_next;
        res_chan_reg  <= res_chan_next;
        res_dir_reg   <= res_dir_next;
        res_que_reg   <= res_que_next;
        o_del_reg     <= o_del_next;
        o_chan_reg    <= o_chan_next;
        o_dir_reg     <= o_dir_next;
        o_que_reg     <= o_que_next;
        o_cb_reg      <= o_cb_next;
        o_prev_reg    <= o_prev_next;
        o_upc_reg     <= o_upc_next;
    end

    assign out_valid            = out_valid_reg;
    assign delivered            = o_del_reg;
    assign delivered_channel    = o_chan_reg;
    assign call_direct          = o_dir_reg;
    assign queue_handler        = o_que_reg;
    assign callback_request     = o_cb_reg;
    assign previous_upcall_mask = o_prev_reg;
    assign upcall_pending_now   = o_upc_reg;

    `ECD_ASSERT_IMPL(a_sel_implies_upcall, clk, rst_n, sel_reg != '0, upc_pend_reg, "selected word without upcall pending")
    `ECD_ASSERT(a_load_from_fin, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_FIN), "result loaded outside finish state")
    `ECD_ASSERT_IMPL(a_flags_need_delivery, clk, rst_n, out_valid_reg && !o_del_reg, !o_dir_reg && !o_que_reg && (o_chan_reg == '0), "handler flags without delivery")
    `ECD_ASSERT_IMPL(a_write_states, clk, rst_n, ram_we, state_reg == S_RMW || state_reg == S_ACK, "row write outside update states")

endmodule

>>> tb/event_channel_demux_top_tb.sv
// ---------------------------------------------------------------------------
// event_channel_demux_top_tb
// Self-checking bench for the event channel demux.
// ---------------------------------------------------------------------------
// Command words go from a queue to a clocked driver with random gaps. A
// bitmap model in the bench predicts each result word. A clocked monitor
// with random stalls compares results field by field, in order.
// ---------------------------------------------------------------------------
module event_channel_demux_top_tb;
    import ecd_pkg::*;

    localparam int NWORDS = DEF_NUM_CHANNELS / DEF_WORD_BITS;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] chan;
        logic              dir;
        logic              que;
        logic              own;
        logic              upm;
    } cmd_t;

    typedef struct packed {
        logic              dlv;
        logic [CHAN_W-1:0] dch;
        logic              cdir;
        logic              qh;
        logic              cbr;
        logic              pum;
        logic              upn;
    } res_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] channel;
    logic has_direct_handler;
    logic has_queued_handler;
    logic owned_by_this_cpu;
    logic upcall_mask_value;
    logic out_valid;
    logic out_stall;
    logic delivered;
    logic [CHAN_W-1:0] delivered_channel;
    logic call_direct;
    logic queue_handler;
    logic callback_request;
    logic previous_upcall_mask;
    logic upcall_pending_now;

    event_channel_demux_top dut (.*);

    // bench copy of the bitmap state
    logic [63:0] pend_q [NWORDS];
    logic [63:0] mask_q [NWORDS];
    logic [63:0] ipi_q [NWORDS];
    logic [63:0] own_q [NWORDS];
    logic [63:0] dir_q [NWORDS];
    logic [63:0] que_q [NWORDS];
    logic [NWORDS-1:0] sel_q;
    logic up_pend;
    logic up_mask;

    cmd_t cmd_queue[$];
    res_t expected_results[$];
    int errors = 0;
    int n_words_out = 0;
    int n_delivered = 0;
    int n_ack = 0;
    int hold_off = 0;
    int in_gap = 0;
    int out_gap = 0;
    int idle_cycles = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [63:0] ready_bits(int w);
        return pend_q[w] & ~mask_q[w] & ~(ipi_q[w] & ~own_q[w]);
    endfunction

    function automatic void open_channel(int w, logic [63:0] b);
        mask_q[w] &= ~b;
        if ((pend_q[w] & b) != 0 && !sel_q[w])
        begin
            sel_q[w] = 1'b1;
            up_pend = 1'b1;
        end
    endfunction

    function automatic res_t demux_predict(cmd_t c);
        res_t r;
        int w;
        logic [63:0] b;
        logic [63:0] d;
        bit found;
        r = '0;
        w = c.chan / DEF_WORD_BITS;
        b = 64'd1 << (c.chan % DEF_WORD_BITS);
        r.pum = up_mask;
        found = 0;
        case (kind_t'(c.kind))
            K_RAISE:
                if ((pend_q[w] & b) == 0)
                begin
                    pend_q[w] |= b;
                    if ((mask_q[w] & b) == 0 && !sel_q[w])
                    begin
                        sel_q[w] = 1'b1;
                        up_pend = 1'b1;
                    end
                end
            K_MASK: mask_q[w] |= b;
            K_UNMASK: open_channel(w, b);
            K_HANDLERS:
            begin
                dir_q[w] = c.dir ? (dir_q[w] | b) : (dir_q[w] & ~b);
                que_q[w] = c.que ? (que_q[w] | b) : (que_q[w] & ~b);
                if (c.dir || c.que)
                    open_channel(w, b);
                else
                    mask_q[w] |= b;
            end
            K_IPI:
            begin
                ipi_q[w] |= b;
                own_q[w] = c.own ? (own_q[w] | b) : (own_q[w] & ~b);
            end
            K_UPMASK: up_mask = c.upm;
            K_ACK:
            begin
                for (int i = 0; i < NWORDS && !found; i++)
                begin
                    if (!sel_q[i])
                        continue;
                    d = ready_bits(i);
                    if (d == 0)
                    begin
                        sel_q[i] = 1'b0;
                        continue;
                    end
                    for (int p = 0; p < 64 && !found; p++)
                    begin
                        if (d[p])
                        begin
                            found = 1;
                            pend_q[i][p] = 1'b0;
                            r.dlv = 1'b1;
                            r.dch = CHAN_W'(i * DEF_WORD_BITS + p);
                            r.cdir = dir_q[i][p];
                            r.qh = que_q[i][p];
                        end
                    end
                    if (ready_bits(i) == 0)
                        sel_q[i] = 1'b0;
                end
                if (sel_q == 0)
                    up_pend = 1'b0;
            end
            default: ;
        endcase
        r.cbr = up_pend && !up_mask;
        r.upn = up_pend;
        return r;
    endfunction

    function automatic cmd_t mk(kind_t k, int ch);
        cmd_t c;
        c.kind = k;
        c.chan = CHAN_W'(ch);
        c.dir = 1'($urandom_range(0, 1));
        c.que = 1'($urandom_range(0, 1));
        c.own = 1'($urandom_range(0, 1));
        c.upm = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // driver: predict on acceptance, then present the next word after a gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(demux_predict(cmd_queue.pop_front()));
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0 || (in_valid && !in_stall))
                begin
                    in_valid <= 1'b0;
                    if (in_valid && !in_stall)
                        in_gap <= $urandom_range(0, 15) * $urandom_range(0, 1);
                    else
                        in_gap <= in_gap - 1;
                end
                else if (cmd_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    kind <= cmd_queue[0].kind;
                    channel <= cmd_queue[0].chan;
                    has_direct_handler <= cmd_queue[0].dir;
                    has_queued_handler <= cmd_queue[0].que;
                    owned_by_this_cpu <= cmd_queue[0].own;
                    upcall_mask_value <= cmd_queue[0].upm;
                end
            end
        end
    end

    // monitor: compare each taken result word, then draw a new stall
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            out_gap <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                got = {delivered, delivered_channel, call_direct, queue_handler,
                       callback_request, previous_upcall_mask, upcall_pending_now};
                n_words_out++;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, got);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.dlv) n_delivered++;
                    if (got.dlv !== exp_r.dlv || got.dch !== exp_r.dch
                        || got.cdir !== exp_r.cdir || got.qh !== exp_r.qh
                        || got.cbr !== exp_r.cbr || got.pum !== exp_r.pum
                        || got.upn !== exp_r.upn)
                    begin
                        errors++;
                        $display("%0t: mismatch exp dlv=%b ch=%0d dir=%b que=%b cb=%b pm=%b up=%b",
                                 $time, exp_r.dlv, exp_r.dch, exp_r.cdir, exp_r.qh,
                                 exp_r.cbr, exp_r.pum, exp_r.upn);
                        $display("%0t:          act dlv=%b ch=%0d dir=%b que=%b cb=%b pm=%b up=%b",
                                 $time, got.dlv, got.dch, got.cdir, got.qh,
                                 got.cbr, got.pum, got.upn);
                    end
                end
                out_gap <= $urandom_range(0, 15) * $urandom_range(0, 1);
                out_stall <= 1'b1;
            end
            else if (hold_off > 0)
                out_stall <= 1'b1;
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // long receiver hold-off while the sender keeps offering
    always @(posedge clk)
    begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
        else if (rst_n && n_words_out == 150)
            hold_off <= 300;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d words still expected", expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        cmd_t c;
        int ch;
        int base;
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b1;
        kind = '0;
        channel = '0;
        has_direct_handler = 1'b0;
        has_queued_handler = 1'b0;
        owned_by_this_cpu = 1'b0;
        upcall_mask_value = 1'b0;
        for (int i = 0; i < NWORDS; i++)
        begin
            pend_q[i] = '0;
            mask_q[i] = '1;
            ipi_q[i] = '0;
            own_q[i] = '0;
            dir_q[i] = '0;
            que_q[i] = '0;
        end
        sel_q = '0;
        up_pend = 1'b0;
        up_mask = 1'b1;

        // directed: empty ack, extremes, foreign IPI skip, unknown kind
        cmd_queue.push_back(mk(K_ACK, 0));
        c = mk(K_UPMASK, 0); c.upm = 1'b0; cmd_queue.push_back(c);
        cmd_queue.push_back(mk(K_RAISE, 4095));
        c = mk(K_HANDLERS, 4095); c.dir = 1; c.que = 1; cmd_queue.push_back(c);
        cmd_queue.push_back(mk(K_RAISE, 0));
        cmd_queue.push_back(mk(K_RAISE, 0));
        cmd_queue.push_back(mk(K_UNMASK, 0));
        c = mk(K_IPI, 1); c.own = 1'b0; cmd_queue.push_back(c);
        cmd_queue.push_back(mk(K_RAISE, 1));
        cmd_queue.push_back(mk(K_UNMASK, 1));
        cmd_queue.push_back(mk(K_ACK, 0));
        cmd_queue.push_back(mk(K_ACK, 0));
        cmd_queue.push_back(mk(K_ACK, 0));
        c = mk(K_IPI, 1); c.own = 1'b1; cmd_queue.push_back(c);
        cmd_queue.push_back(mk(K_ACK, 0));
        cmd_queue.push_back(mk(K_MASK, 63));
        cmd_queue.push_back(mk(K_RAISE, 63));
        c = mk(K_HANDLERS, 63); c.dir = 0; c.que = 0; cmd_queue.push_back(c);
        cmd_queue.push_back(mk(K_ACK, 0));
        cmd_queue.push_back(mk(K_NONE, 2730));
        c = mk(K_UPMASK, 0); c.upm = 1'b1; cmd_queue.push_back(c);
        cmd_queue.push_back(mk(K_ACK, 0));

        // random: mostly clustered channels so raises meet unmasks and acks
        for (int n = 0; n < 500; n++)
        begin
            base = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                            : $urandom_range(0, 3) * 1024 + 60;
            ch = (base + $urandom_range(0, 7)) % 4096;
            k = $urandom_range(0, 19);
            if (k < 5) c = mk(K_RAISE, ch);
            else if (k < 6) c = mk(K_MASK, ch);
            else if (k < 8) c = mk(K_UNMASK, ch);
            else if (k < 10) c = mk(K_HANDLERS, ch);
            else if (k < 11) c = mk(K_IPI, ch);
            else if (k < 12) c = mk(K_UPMASK, ch);
            else if (k < 13) c = mk(K_NONE, ch);
            else c = mk(K_ACK, $urandom_range(0, 4095));
            cmd_queue.push_back(c);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (cmd_queue.size() == 0);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge clk);
        $display("covered %0d result words, %0d with a served channel", n_words_out,
                 n_delivered);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
